// ===== sv/oid_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// OID decoder package
// Shared types, constants and error codes for the ASN.1 OBJECT IDENTIFIER
// arc decoder and its result queue.
// ----------------------------------------------------------------------------
package oid_pkg;

  // Sub-identifier accumulator width and octet limit per sub-identifier.
  localparam int unsigned ArcBits      = 32;
  localparam int unsigned MaxArcOctets = 5;
  localparam int unsigned OctW         = $clog2(MaxArcOctets + 1);

  // Result queue depth; two free entries are needed to take an octet.
  localparam int unsigned ResDepth = 4;
  localparam int unsigned ResPtrW  = $clog2(ResDepth);
  localparam int unsigned ResCntW  = $clog2(ResDepth + 1);

  // Configuration port.
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  // Value of address bit 2 that selects the capacity register.
  localparam logic RegMaxArcs = 1'b0;

  // Split points of the first sub-identifier.
  localparam logic [ArcBits-1:0] Arc1Split = ArcBits'(40);
  localparam logic [ArcBits-1:0] Arc2Split = ArcBits'(80);

  // Reset value of the capacity register.
  localparam logic [15:0] MaxArcsReset = 16'hffff;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_LEAD_80   = 3'd1,
    ERR_OVERFLOW  = 3'd2,
    ERR_TOO_LONG  = 3'd3,
    ERR_TRUNCATED = 3'd4,
    ERR_TOO_MANY  = 3'd5
  } oid_err_e;

  // One input transaction.
  typedef struct packed {
    logic [7:0] octet;
    logic       last;
  } oid_in_t;

  // One result transaction.
  typedef struct packed {
    logic [31:0] arc_value;
    logic        arc_valid;
    logic [15:0] arc_count;
    oid_err_e    error_code;
    logic        done_res;
  } oid_res_t;

  // Write request into the result queue: up to two results per octet.
  typedef struct packed {
    logic     push0;
    logic     push1;
    oid_res_t res0;
    oid_res_t res1;
  } oid_push_t;

endpackage
`default_nettype wire

// ===== sv/oid_arc_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// OID arc decoder
// Decodes ASN.1 BER OBJECT IDENTIFIER content octets into arcs, one octet per
// transaction, with error reporting and a configurable arc capacity.
// ----------------------------------------------------------------------------
// Results are registered in the result queue and offered on the output from there.
// Throughput: one octet per cycle while the queue has room; the first sub-identifier yields two
// results, which a four-entry result queue absorbs while input continues.
// Input is held off only when the result queue has fewer than two free slots.
// Reset: asynchronous, active low; decoder state cleared, queue emptied,
// capacity register set to 65535.
module oid_arc_decoder (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Octet input channel
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire oid_pkg::oid_in_t                 in_data_i,
  // Result output channel
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output oid_pkg::oid_res_t                     out_data_o,
  // Configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [oid_pkg::CfgAddrW-1:0]     paddr,
  input  wire logic [oid_pkg::CfgDataW-1:0]     pwdata,
  output logic [oid_pkg::CfgDataW-1:0]          prdata,
  output logic                                  pready
);
  import oid_pkg::*;

  logic [ArcBits-1:0] acc_q, acc_d;
  logic [OctW-1:0]    oct_q, oct_d;
  logic               first_q, first_d;
  logic [15:0]        arcs_q, arcs_d;
  oid_err_e           sticky_q, sticky_d;
  logic [15:0]        max_arcs_q;

  logic               accept;
  logic               room2;
  logic               cfg_wr;
  oid_push_t          push;

  logic [ArcBits-1:0] acc_shift;
  logic [OctW-1:0]    oct_inc;
  oid_err_e           err;
  logic               arc_done;
  logic [ArcBits-1:0] a1_val;
  logic [1:0]         a0_val;

  assign accept     = in_valid_i & in_ready_o;
  assign in_ready_o = room2;

  // Configuration register access.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegMaxArcs) begin
      prdata = CfgDataW'(max_arcs_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_arcs_q <= MaxArcsReset;
    end else if (cfg_wr && (paddr[2] == RegMaxArcs)) begin
      max_arcs_q <= pwdata[15:0];
    end
  end

  // Next accumulator value and octet count for the incoming octet.
  assign acc_shift = {acc_q[ArcBits-8:0], in_data_i.octet[6:0]};
  assign oct_inc   = oct_q + OctW'(1);

  // Split of the first sub-identifier into its two arcs.
  always_comb begin
    if (acc_shift < Arc1Split) begin
      a0_val = 2'd0;
      a1_val = acc_shift;
    end else if (acc_shift < Arc2Split) begin
      a0_val = 2'd1;
      a1_val = acc_shift - Arc1Split;
    end else begin
      a0_val = 2'd2;
      a1_val = acc_shift - Arc2Split;
    end
  end

  // Octet decode: error checks, arc completion and result generation.
  always_comb begin
    acc_d    = acc_q;
    oct_d    = oct_q;
    first_d  = first_q;
    arcs_d   = arcs_q;
    sticky_d = sticky_q;
    err      = sticky_q;
    arc_done = 1'b0;
    push     = '0;

    if (accept) begin
      if (sticky_q == ERR_NONE) begin
        // Capacity and leading-zero checks on a sub-identifier's first octet.
        if (oct_q == '0) begin
          if (first_q ? (max_arcs_q < 16'd2) : (arcs_q >= max_arcs_q)) begin
            err = ERR_TOO_MANY;
          end else if (in_data_i.octet == 8'h80) begin
            err = ERR_LEAD_80;
          end
        end
        // Set bits would be shifted out of the accumulator.
        if ((err == ERR_NONE) && (oct_q != '0) &&
            (acc_q[ArcBits-1:ArcBits-7] != '0)) begin
          err = ERR_OVERFLOW;
        end
        if (err == ERR_NONE) begin
          if (!in_data_i.octet[7]) begin
            // Sub-identifier complete: emit its arc or arcs.
            arc_done = 1'b1;
            if (first_q) begin
              push.push0          = 1'b1;
              push.res0.arc_value = 32'(a0_val);
              push.res0.arc_valid = 1'b1;
              push.res0.arc_count = 16'd1;
              push.res0.error_code = ERR_NONE;
              push.res0.done_res  = 1'b0;
              push.push1          = 1'b1;
              push.res1.arc_value = 32'(a1_val);
              push.res1.arc_valid = 1'b1;
              push.res1.arc_count = 16'd2;
              push.res1.error_code = ERR_NONE;
              push.res1.done_res  = in_data_i.last;
              arcs_d              = 16'd2;
              first_d             = 1'b0;
            end else begin
              arcs_d              = arcs_q + 16'd1;
              push.push0          = 1'b1;
              push.res0.arc_value = 32'(acc_shift);
              push.res0.arc_valid = 1'b1;
              push.res0.arc_count = arcs_d;
              push.res0.error_code = ERR_NONE;
              push.res0.done_res  = in_data_i.last;
            end
            acc_d = '0;
            oct_d = '0;
            if (in_data_i.last) begin
              arcs_d  = '0;
              first_d = 1'b1;
            end
          end else begin
            // Continuation octet: gather and check length and truncation.
            acc_d = acc_shift;
            oct_d = oct_inc;
            if (oct_inc >= OctW'(MaxArcOctets)) begin
              err = ERR_TOO_LONG;
            end else if (in_data_i.last) begin
              err = ERR_TRUNCATED;
            end
          end
        end
      end

      // Error or open identifier: hold the error, close it on the last octet.
      if (!arc_done) begin
        sticky_d = err;
        if (in_data_i.last) begin
          push.push0           = 1'b1;
          push.res0.arc_value  = '0;
          push.res0.arc_valid  = 1'b0;
          push.res0.arc_count  = arcs_q;
          push.res0.error_code = err;
          push.res0.done_res   = 1'b1;
          acc_d    = '0;
          oct_d    = '0;
          first_d  = 1'b1;
          arcs_d   = '0;
          sticky_d = ERR_NONE;
        end
      end
    end
  end

  // Decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      oct_q    <= '0;
      first_q  <= 1'b1;
      arcs_q   <= '0;
      sticky_q <= ERR_NONE;
    end else begin
      acc_q    <= acc_d;
      oct_q    <= oct_d;
      first_q  <= first_d;
      arcs_q   <= arcs_d;
      sticky_q <= sticky_d;
    end
  end

  // Result queue between the decoder and the output channel.
  oid_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ===== sv/oid_res_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// OID result queue
// Small register queue that takes up to two results in one cycle and hands
// one per cycle to the output channel while it is ready.
// ----------------------------------------------------------------------------
module oid_res_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire oid_pkg::oid_push_t push_i,
  output logic                    room2_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output oid_pkg::oid_res_t       out_data_o
);
  import oid_pkg::*;

  oid_res_t             mem_q [ResDepth];
  logic [ResPtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [ResCntW-1:0]   count_q, count_d;
  logic                 pop;
  logic [ResPtrW-1:0]   wr_ptr_nxt;

  // Handshake on the output side.
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o & out_ready_i;
  assign room2_o     = (count_q <= ResCntW'(ResDepth - 2));
  assign wr_ptr_nxt  = wr_ptr_q + ResPtrW'(1);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + ResPtrW'(push_i.push0) + ResPtrW'(push_i.push1);
    rd_ptr_d = rd_ptr_q + ResPtrW'(pop);
    count_d  = count_q + ResCntW'(push_i.push0) + ResCntW'(push_i.push1)
               - ResCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Result storage; the second result goes behind the first.
  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.push1) begin
      mem_q[wr_ptr_nxt] <= push_i.res1;
    end
  end

endmodule
`default_nettype wire

// ===== dv/oid_arc_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// OID arc decoder testbench
// Streams OBJECT IDENTIFIER content octets into the decoder, predicts every
// arc and error transaction with an independent decoder model, and checks the
// results in order, mostly while both channels stall at random.
// ----------------------------------------------------------------------------
module oid_arc_decoder_tb;
  import oid_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReports = 10;

  // Clock, reset and the signals that drive the block.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  oid_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  oid_res_t out_data;
  logic apb_sel = 1'b0;
  logic apb_enable = 1'b0;
  logic apb_write = 1'b0;
  logic [CfgAddrW-1:0] apb_addr = '0;
  logic [CfgDataW-1:0] apb_wdata = '0;
  logic [CfgDataW-1:0] apb_rdata;
  logic apb_ready;

  // Octets waiting to be sent and arcs waiting to come out.
  oid_in_t octet_q[$];
  oid_res_t arc_results_q[$];
  int unsigned n_in_sent = 0;
  int unsigned n_in_acc = 0;
  int unsigned n_errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Decoder model state.
  logic [ArcBits-1:0] arc_acc;
  logic [OctW-1:0] grp_cnt;
  logic first_pend;
  logic [15:0] arcs_seen;
  oid_err_e held_err;
  logic [15:0] max_arcs_cfg;

  oid_arc_decoder u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (apb_sel),
    .penable    (apb_enable),
    .pwrite     (apb_write),
    .paddr      (apb_addr),
    .pwdata     (apb_wdata),
    .prdata     (apb_rdata),
    .pready     (apb_ready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("oid_arc_decoder_tb: errors");
      $finish;
    end
  end

  function automatic oid_res_t mk_res(logic [31:0] value, logic valid, logic [15:0] count,
                                      oid_err_e err, logic done);
    oid_res_t r;
    r.arc_value = value;
    r.arc_valid = valid;
    r.arc_count = count;
    r.error_code = err;
    r.done_res = done;
    return r;
  endfunction

  // Start a fresh identifier in the model.
  task automatic clear_oid();
    arc_acc = '0;
    grp_cnt = '0;
    first_pend = 1'b1;
    arcs_seen = '0;
    held_err = ERR_NONE;
  endtask

  // Model one accepted octet and queue the arcs or error that it causes.
  task automatic decode_octet(input oid_in_t it);
    oid_err_e err;
    logic [ArcBits-1:0] v;
    logic arc_closed;
    err = held_err;
    arc_closed = 1'b0;
    if (err == ERR_NONE) begin
      if (grp_cnt == 0) begin
        if (first_pend ? (max_arcs_cfg < 16'd2) : (arcs_seen >= max_arcs_cfg)) begin
          err = ERR_TOO_MANY;
        end else if (it.octet == 8'h80) begin
          err = ERR_LEAD_80;
        end
      end
      if (err == ERR_NONE && grp_cnt != 0 && arc_acc[ArcBits-1 -: 7] != 7'd0) begin
        err = ERR_OVERFLOW;
      end
      if (err == ERR_NONE) begin
        arc_acc = {arc_acc[ArcBits-8:0], it.octet[6:0]};
        grp_cnt = grp_cnt + 1'b1;
        if (!it.octet[7]) begin
          // Sub-identifier complete: the first one splits into two arcs.
          arc_closed = 1'b1;
          v = arc_acc;
          if (first_pend) begin
            if (v < Arc1Split) begin
              arc_results_q.push_back(mk_res(32'd0, 1'b1, 16'd1, ERR_NONE, 1'b0));
              arc_results_q.push_back(mk_res(v, 1'b1, 16'd2, ERR_NONE, it.last));
            end else if (v < Arc2Split) begin
              arc_results_q.push_back(mk_res(32'd1, 1'b1, 16'd1, ERR_NONE, 1'b0));
              arc_results_q.push_back(mk_res(v - Arc1Split, 1'b1, 16'd2, ERR_NONE, it.last));
            end else begin
              arc_results_q.push_back(mk_res(32'd2, 1'b1, 16'd1, ERR_NONE, 1'b0));
              arc_results_q.push_back(mk_res(v - Arc2Split, 1'b1, 16'd2, ERR_NONE, it.last));
            end
            arcs_seen = 16'd2;
            first_pend = 1'b0;
          end else begin
            arcs_seen = arcs_seen + 16'd1;
            arc_results_q.push_back(mk_res(v, 1'b1, arcs_seen, ERR_NONE, it.last));
          end
          arc_acc = '0;
          grp_cnt = '0;
          if (it.last) begin
            clear_oid();
          end
        end else if (grp_cnt >= MaxArcOctets) begin
          err = ERR_TOO_LONG;
        end else if (it.last) begin
          err = ERR_TRUNCATED;
        end
      end
      if (!arc_closed) begin
        held_err = err;
      end
    end
    // The flagged octet closes the identifier with the error held so far.
    if (!arc_closed && it.last) begin
      arc_results_q.push_back(mk_res(32'd0, 1'b0, arcs_seen, err, 1'b1));
      clear_oid();
    end
  endtask

  // Octet driver: holds each transaction until it is taken.
  always @(negedge clk) begin
    if (!in_valid || n_in_acc == n_in_sent) begin
      if (octet_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data <= octet_q.pop_front();
        in_valid <= 1'b1;
        n_in_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Result monitor and model update at the clock edge.
  always @(posedge clk) begin : mon
    oid_res_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (arc_results_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MaxReports) begin
            $display("unexpected result: value %h valid %b count %0d err %0d done %b",
                     out_data.arc_value, out_data.arc_valid, out_data.arc_count,
                     out_data.error_code, out_data.done_res);
          end
        end else begin
          want = arc_results_q.pop_front();
          if (out_data.arc_value !== want.arc_value || out_data.arc_valid !== want.arc_valid ||
              out_data.arc_count !== want.arc_count ||
              out_data.error_code !== want.error_code ||
              out_data.done_res !== want.done_res) begin
            n_errors++;
            if (n_errors <= MaxReports) begin
              $display("mismatch: expected value %h valid %b count %0d err %0d done %b",
                       want.arc_value, want.arc_valid, want.arc_count, want.error_code,
                       want.done_res);
              $display("          actual   value %h valid %b count %0d err %0d done %b",
                       out_data.arc_value, out_data.arc_valid, out_data.arc_count,
                       out_data.error_code, out_data.done_res);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_octet(in_data);
        n_in_acc++;
      end
    end
  end

  task automatic queue_octet(input logic [7:0] octet, input logic last);
    oid_in_t it;
    it.octet = octet;
    it.last = last;
    octet_q.push_back(it);
  endtask

  // One random identifier: mostly well formed, some broken, some plain noise.
  task automatic queue_oid();
    logic [7:0] oct_q[$];
    logic [6:0] grp;
    int unsigned n_sub, cap, len, r, pos, i, s;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      len = $urandom_range(1, 6);
      for (i = 0; i < len; i++) begin
        queue_octet(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
      end
    end else begin
      cap = (max_arcs_cfg < 16'd8) ? max_arcs_cfg : 8;
      n_sub = $urandom_range(1, cap);
      for (s = 0; s < n_sub; s++) begin
        r = $urandom_range(0, 99);
        len = (r < 50) ? 1 : (r < 70) ? 2 : (r < 80) ? 3 : (r < 88) ? 4 : (r < 98) ? 5 : 6;
        for (i = 0; i < len; i++) begin
          grp = 7'($urandom_range(0, 127));
          if (i == 0 && len > 1) begin
            // Five-octet arcs mostly fit in 32 bits; the rest may overflow.
            if (len == 5 && $urandom_range(0, 4) != 0) begin
              grp = 7'($urandom_range(1, 15));
            end else begin
              grp = 7'($urandom_range(1, 127));
            end
          end
          oct_q.push_back({(i != len - 1), grp});
        end
      end
      // Break some identifiers: cut short, or one octet replaced.
      if ($urandom_range(0, 99) < 17) begin
        pos = $urandom_range(0, oct_q.size() - 1);
        case ($urandom_range(0, 2))
          0: begin
            while (oct_q.size() > pos + 1) begin
              void'(oct_q.pop_back());
            end
          end
          1: begin
            oct_q[pos] = 8'($urandom_range(0, 255));
          end
          default: begin
            oct_q[pos] = 8'h80;
          end
        endcase
      end
      for (i = 0; i < oct_q.size(); i++) begin
        queue_octet(oct_q[i], (i == oct_q.size() - 1));
      end
    end
  endtask

  task automatic queue_random(input int unsigned n_items);
    int unsigned target;
    target = octet_q.size() + n_items;
    while (octet_q.size() < target) begin
      queue_oid();
    end
  endtask

  // Wait until every octet has been taken and every result has arrived.
  task automatic wait_idle();
    while (octet_q.size() != 0 || in_valid || arc_results_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [CfgAddrW-1:0] addr,
                          input logic [CfgDataW-1:0] wdata, output logic [CfgDataW-1:0] rdata);
    @(negedge clk);
    apb_sel <= 1'b1;
    apb_enable <= 1'b0;
    apb_write <= wr;
    apb_addr <= addr;
    apb_wdata <= wdata;
    @(negedge clk);
    apb_enable <= 1'b1;
    do begin
      @(posedge clk);
    end while (!apb_ready);
    rdata = apb_rdata;
    @(negedge clk);
    apb_sel <= 1'b0;
    apb_enable <= 1'b0;
  endtask

  // Write the capacity register while the block is idle and read it back.
  task automatic set_max_arcs(input logic [15:0] value);
    logic [CfgAddrW-1:0] addr;
    logic [CfgDataW-1:0] rd;
    addr = CfgAddrW'({RegMaxArcs, 2'b00});
    wait_idle();
    apb_xfer(1'b1, addr, CfgDataW'(value), rd);
    max_arcs_cfg = value;
    apb_xfer(1'b0, addr, '0, rd);
    if (rd[15:0] !== value) begin
      n_errors++;
      if (n_errors <= MaxReports) begin
        $display("max_arcs readback: expected %h actual %h", value, rd[15:0]);
      end
    end
  endtask

  initial begin
    clear_oid();
    max_arcs_cfg = MaxArcsReset;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Receiver idles more than sender.
    send_idle_pct = 37;
    recv_idle_pct = 50;

    // Single-octet identifiers at zero and across both split points.
    queue_octet(8'h00, 1'b1);
    queue_octet(8'h27, 1'b1);
    queue_octet(8'h28, 1'b1);
    queue_octet(8'h4f, 1'b1);
    queue_octet(8'h50, 1'b1);
    // Largest 32-bit arc after 1.2.
    queue_octet(8'h2a, 1'b0);
    queue_octet(8'h8f, 1'b0);
    queue_octet(8'hff, 1'b0);
    queue_octet(8'hff, 1'b0);
    queue_octet(8'hff, 1'b0);
    queue_octet(8'h7f, 1'b1);
    // Overflow on the fifth octet of the first sub-identifier.
    queue_octet(8'h90, 1'b0);
    queue_octet(8'h80, 1'b0);
    queue_octet(8'h80, 1'b0);
    queue_octet(8'h80, 1'b0);
    queue_octet(8'h00, 1'b1);
    // Continuation on the fifth octet, which is also the last one.
    queue_octet(8'h81, 1'b0);
    queue_octet(8'h80, 1'b0);
    queue_octet(8'h80, 1'b0);
    queue_octet(8'h80, 1'b0);
    queue_octet(8'h80, 1'b1);
    // Leading zero group, then the dropped octet closing with the error.
    queue_octet(8'h80, 1'b0);
    queue_octet(8'h01, 1'b1);
    // Last octet leaves a sub-identifier open.
    queue_octet(8'h2a, 1'b0);
    queue_octet(8'h81, 1'b1);

    // Capacity of two: a third arc is refused.
    set_max_arcs(16'd2);
    queue_octet(8'h2a, 1'b0);
    queue_octet(8'h01, 1'b1);
    queue_random(170);

    // Sender idles more than receiver.
    set_max_arcs(16'd3);
    send_idle_pct = 50;
    recv_idle_pct = 37;
    queue_random(170);
    set_max_arcs(16'($urandom_range(4, 20)));
    queue_random(230);

    // Full rate on both sides.
    set_max_arcs(16'hffff);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(230);
    set_max_arcs(16'($urandom_range(2, 65535)));
    queue_random(220);

    wait_idle();
    if (n_errors == 0) begin
      $display("oid_arc_decoder_tb: clean");
    end else begin
      $display("oid_arc_decoder_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/oid_pkg.sv
sv/oid_res_fifo.sv
sv/oid_arc_decoder.sv
dv/oid_arc_decoder_tb.sv
